### hdl/ohd_pkg.sv
// Shared types and codes for the output hold table.
// Used by ohd_ram users, ohd_eval and output_hold_deadman_table; no dependencies.
package ohd_pkg;

    localparam logic [3:0] MODE_REGISTER   = 4'd0;
    localparam logic [3:0] MODE_FORGET_CH  = 4'd1;
    localparam logic [3:0] MODE_FORGET_DEV = 4'd2;
    localparam logic [3:0] MODE_COMMAND    = 4'd3;
    localparam logic [3:0] MODE_RENEW      = 4'd4;
    localparam logic [3:0] MODE_RELEASE    = 4'd5;
    localparam logic [3:0] MODE_TRIP       = 4'd6;
    localparam logic [3:0] MODE_CLEAR      = 4'd7;
    localparam logic [3:0] MODE_HEALTH     = 4'd8;
    localparam logic [3:0] MODE_TICK       = 4'd9;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BADARG    = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_INTERLOCK = 3'd3;
    localparam logic [2:0] ST_NOTFOUND  = 3'd4;
    localparam logic [2:0] ST_BADSTATE  = 3'd5;

    localparam logic [2:0] HS_SAFE    = 3'd0;
    localparam logic [2:0] HS_CMD     = 3'd1;
    localparam logic [2:0] HS_EXPIRED = 3'd2;
    localparam logic [2:0] HS_FAULT   = 3'd3;
    localparam logic [2:0] HS_TRIPPED = 3'd4;

    localparam logic [1:0] CAUSE_TRIP    = 2'd0;
    localparam logic [1:0] CAUSE_STOPPED = 2'd1;
    localparam logic [1:0] CAUSE_EXPIRED = 2'd2;

    localparam logic [2:0] SEV_NONE  = 3'd0;
    localparam logic [2:0] SEV_EVENT = 3'd3;
    localparam logic [2:0] SEV_TRIP  = 3'd4;

    localparam logic [7:0] NO_CHANNEL = 8'hFF;

    typedef struct packed {
        logic [3:0]  mode;
        logic [7:0]  channel_id;
        logic [7:0]  device_id;
        logic [31:0] level_bits;
        logic [31:0] hold_timeout;
        logic        healthy;
        logic [2:0]  release_state;
        logic [63:0] now_us;
    } ohd_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_channel;
        logic [31:0] applied_bits;
        logic        drive_valid;
        logic [2:0]  hold_state;
        logic        event_valid;
        logic [1:0]  event_cause;
        logic [2:0]  severity;
        logic        tripped;
        logic [15:0] trip_count;
        logic [15:0] expiry_count;
        logic        last;
    } ohd_out_t;

    // per-result fields before the trip state, counters and last are attached
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_channel;
        logic [31:0] applied_bits;
        logic        drive_valid;
        logic [2:0]  hold_state;
        logic        event_valid;
        logic [1:0]  event_cause;
        logic [2:0]  severity;
    } ohd_res_t;

    typedef struct packed {
        logic [7:0]  channel;
        logic [7:0]  device;
        logic [31:0] safe_bits;
        logic [31:0] timeout;
        logic [63:0] cmd_time;
        logic [2:0]  hold_state;
        logic        published;
    } ohd_ent_t;

    typedef struct packed {
        logic     dev_match;
        logic     expire;
        logic     cand;
        logic     wr;
        ohd_ent_t wdata;
        ohd_res_t res;
    } ohd_eval_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK_RD,
        S_LOOK_CHK,
        S_ACT,
        S_WALK_RD,
        S_WALK_CHK,
        S_DROP_RD,
        S_DROP_CHK,
        S_COPY_RD,
        S_COPY_WR,
        S_FIN
    } ohd_state_t;

    function automatic logic is_finite(input logic [31:0] bits);
        return bits[30:23] != 8'hFF;
    endfunction

    function automatic ohd_res_t plain_res(input logic [2:0] st, input logic [7:0] ch);
        ohd_res_t r;
        r = '0;
        r.status = st;
        r.out_channel = ch;
        return r;
    endfunction

endpackage

### hdl/ohd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ohd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/ohd_eval.sv
// Per-entry evaluation unit shared by every table walk: match, expiry compare,
// write-back entry and result. Depends on ohd_pkg.
module ohd_eval
    import ohd_pkg::*;
(
    input  ohd_in_t   item,
    input  logic      pass,
    input  ohd_ent_t  ent,
    output ohd_eval_t ev
);
    logic [63:0] elapsed;

    assign elapsed = item.now_us - ent.cmd_time;

    always_comb begin
        ev = '0;
        ev.wdata = ent;
        ev.res = plain_res(ST_OK, ent.channel);
        ev.res.applied_bits = ent.safe_bits;
        ev.dev_match = (ent.device == item.device_id);
        ev.expire = (ent.hold_state == HS_CMD) && (ent.timeout != '0)
                    && (item.now_us >= ent.cmd_time)
                    && (elapsed >= {32'd0, ent.timeout});
        case (item.mode)
            MODE_TRIP: begin
                ev.wr = 1'b1;
                ev.cand = 1'b1;
                ev.wdata.hold_state = HS_TRIPPED;
                ev.res.drive_valid = 1'b1;
                ev.res.hold_state = HS_TRIPPED;
                ev.res.event_valid = 1'b1;
                ev.res.event_cause = CAUSE_TRIP;
                ev.res.severity = SEV_TRIP;
            end
            MODE_CLEAR: begin
                ev.wr = 1'b1;
                ev.wdata.hold_state = HS_SAFE;
            end
            MODE_HEALTH: begin
                if (ev.dev_match && !item.healthy) begin
                    ev.wr = 1'b1;
                    ev.cand = 1'b1;
                    ev.wdata.hold_state = HS_FAULT;
                    ev.res.hold_state = HS_FAULT;
                    ev.res.event_valid = 1'b1;
                    ev.res.event_cause = CAUSE_STOPPED;
                    ev.res.severity = SEV_EVENT;
                end else if (ev.dev_match
                             && (ent.hold_state == HS_FAULT || !ent.published)) begin
                    ev.wr = 1'b1;
                    ev.cand = 1'b1;
                    ev.wdata.hold_state = HS_SAFE;
                    ev.wdata.published = 1'b1;
                    ev.res.drive_valid = 1'b1;
                    ev.res.hold_state = HS_SAFE;
                end
            end
            MODE_TICK: begin
                // first pass only counts, second pass applies and reports
                if (ev.expire && pass) begin
                    ev.wr = 1'b1;
                    ev.cand = 1'b1;
                    ev.wdata.hold_state = HS_EXPIRED;
                    ev.res.drive_valid = 1'b1;
                    ev.res.hold_state = HS_EXPIRED;
                    ev.res.event_valid = 1'b1;
                    ev.res.event_cause = CAUSE_EXPIRED;
                    ev.res.severity = SEV_EVENT;
                end
            end
            default: begin
                ev.wr = 1'b0;
            end
        endcase
    end
endmodule

### hdl/output_hold_deadman_table.sv
// Output hold table with deadman release: top level, sequencer and output register.
// Depends on ohd_pkg, ohd_ram and ohd_eval.
//
// Usage: one item enters on s_valid/s_ready (s_data) and gives one or more result
// beats on m_valid/m_ready (m_data); m_data.last marks the final beat of an item.
// s_ready is high only while the sequencer is idle, so one item is in work at a time.
// The table sits in one RAM with a registered read port and a single evaluation
// unit; each entry visited takes an address state, then a check/write state.
// Lookup modes (register, forget, command, renew, release) scan until a match;
// trip and health walk the whole table, clear only while tripped; tick, unless
// tripped, walks it twice (count pass then apply pass); forget channel and forget
// device copy the last entry into each removed slot.
// Per-entry results are held one deep so the final one can carry last; the walk
// waits whenever a new result is found while one is held and the beat is stalled.
// The output register lets the next item start while the last beat waits.
// Reset (aresetn low, synchronous) empties the table and clears the trip latch
// and both counters; entry contents are not cleared and need no clearing pass.
module output_hold_deadman_table
    import ohd_pkg::*;
#(
    parameter int MAX_OUTPUTS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ohd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ohd_out_t m_data
);
    localparam int CW = $clog2(MAX_OUTPUTS + 1);
    localparam int AW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int EW = $bits(ohd_ent_t);

    ohd_state_t state_reg, state_next;
    ohd_in_t    item_reg, item_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic       found_reg, found_next;
    ohd_ent_t   ent_reg, ent_next;
    ohd_res_t   pend_reg, pend_next;
    logic       pend_valid_reg, pend_valid_next;
    logic       pass_reg, pass_next;
    logic       latch_reg, latch_next;
    logic [15:0] trips_reg, trips_next;
    logic [15:0] exp_reg, exp_next;
    logic       m_valid_reg, m_valid_next;
    ohd_out_t   m_data_reg, m_data_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    ohd_ent_t      ram_wdata, ram_rdata;
    logic [EW-1:0] ram_rbits;
    ohd_eval_t     ev;

    logic          out_free, accept, can_go, load, load_last;
    ohd_res_t      load_res;
    logic [CW-1:0] idx_m1, cnt_m1;

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign idx_m1   = idx_reg - 1'b1;
    assign cnt_m1   = cnt_reg - 1'b1;
    assign can_go   = !(ev.cand && pend_valid_reg && !out_free);
    assign ram_rdata = ohd_ent_t'(ram_rbits);

    ohd_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_OUTPUTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    ohd_eval u_eval (
        .item (item_reg),
        .pass (pass_reg),
        .ent  (ram_rdata),
        .ev   (ev)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (s_data.mode)
                        MODE_REGISTER: begin
                            if (s_data.channel_id == NO_CHANNEL
                                || !is_finite(s_data.level_bits)) begin
                                state_next = S_FIN;
                            end else begin
                                state_next = S_LOOK_RD;
                            end
                        end
                        MODE_FORGET_CH, MODE_COMMAND, MODE_RENEW, MODE_RELEASE: begin
                            state_next = S_LOOK_RD;
                        end
                        MODE_FORGET_DEV: state_next = S_DROP_RD;
                        MODE_TRIP, MODE_HEALTH: state_next = S_WALK_RD;
                        MODE_CLEAR: state_next = latch_reg ? S_WALK_RD : S_FIN;
                        MODE_TICK: state_next = latch_reg ? S_FIN : S_WALK_RD;
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_LOOK_RD: state_next = (idx_reg == cnt_reg) ? S_ACT : S_LOOK_CHK;
            S_LOOK_CHK: begin
                state_next = (ram_rdata.channel == item_reg.channel_id) ? S_ACT : S_LOOK_RD;
            end
            S_ACT: begin
                state_next = (item_reg.mode == MODE_FORGET_CH && found_reg) ? S_COPY_RD : S_FIN;
            end
            S_WALK_RD: begin
                if (idx_reg != cnt_reg) begin
                    state_next = S_WALK_CHK;
                end else if (item_reg.mode == MODE_TICK && !pass_reg) begin
                    state_next = S_WALK_RD;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_WALK_CHK: state_next = can_go ? S_WALK_RD : S_WALK_CHK;
            S_DROP_RD: state_next = (idx_reg == '0) ? S_FIN : S_DROP_CHK;
            S_DROP_CHK: state_next = ev.dev_match ? S_COPY_RD : S_DROP_RD;
            S_COPY_RD: state_next = S_COPY_WR;
            S_COPY_WR: state_next = (item_reg.mode == MODE_FORGET_DEV) ? S_DROP_RD : S_FIN;
            S_FIN: state_next = out_free ? S_IDLE : S_FIN;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and table control
    always_comb begin
        item_next = item_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        dst_next = dst_reg;
        found_next = found_reg;
        ent_next = ent_reg;
        pend_next = pend_reg;
        pend_valid_next = pend_valid_reg;
        pass_next = pass_reg;
        latch_next = latch_reg;
        trips_next = trips_reg;
        exp_next = exp_reg;
        ram_we = 1'b0;
        ram_waddr = dst_reg;
        ram_wdata = ent_reg;
        ram_raddr = idx_reg[AW-1:0];
        load = 1'b0;
        load_last = 1'b0;
        load_res = pend_reg;
        s_ready = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    item_next = s_data;
                    idx_next = (s_data.mode == MODE_FORGET_DEV) ? cnt_reg : '0;
                    found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    pass_next = 1'b0;
                    case (s_data.mode)
                        MODE_REGISTER: begin
                            if (s_data.channel_id == NO_CHANNEL
                                || !is_finite(s_data.level_bits)) begin
                                pend_next = plain_res(ST_BADARG, s_data.channel_id);
                                pend_valid_next = 1'b1;
                            end
                        end
                        MODE_FORGET_CH, MODE_FORGET_DEV, MODE_COMMAND, MODE_RENEW,
                        MODE_RELEASE, MODE_HEALTH, MODE_TICK: begin
                            pend_valid_next = 1'b0;
                        end
                        MODE_TRIP: begin
                            latch_next = 1'b1;
                            if (trips_reg != 16'hFFFF) begin
                                trips_next = trips_reg + 16'd1;
                            end
                        end
                        MODE_CLEAR: latch_next = 1'b0;
                        default: begin
                            pend_next = plain_res(ST_BADARG, s_data.channel_id);
                            pend_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_LOOK_CHK: begin
                if (ram_rdata.channel == item_reg.channel_id) begin
                    found_next = 1'b1;
                    ent_next = ram_rdata;
                    dst_next = idx_reg[AW-1:0];
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_ACT: begin
                pend_valid_next = 1'b1;
                pend_next = plain_res(ST_OK, item_reg.channel_id);
                ram_wdata = ent_reg;
                case (item_reg.mode)
                    MODE_REGISTER: begin
                        if (!found_reg && cnt_reg >= CW'(MAX_OUTPUTS)) begin
                            pend_next.status = ST_FULL;
                        end else begin
                            ram_we = 1'b1;
                            ram_waddr = found_reg ? dst_reg : cnt_reg[AW-1:0];
                            ram_wdata.channel = item_reg.channel_id;
                            ram_wdata.device = item_reg.device_id;
                            ram_wdata.safe_bits = item_reg.level_bits;
                            ram_wdata.timeout = item_reg.hold_timeout;
                            ram_wdata.cmd_time = '0;
                            ram_wdata.hold_state = HS_SAFE;
                            ram_wdata.published = 1'b0;
                            pend_next.applied_bits = item_reg.level_bits;
                            if (!found_reg) begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                    end
                    MODE_COMMAND: begin
                        if (latch_reg) begin
                            pend_next.status = ST_INTERLOCK;
                        end else if (!found_reg) begin
                            pend_next.status = ST_NOTFOUND;
                        end else if (!is_finite(item_reg.level_bits)) begin
                            pend_next.status = ST_BADARG;
                        end else if (ent_reg.hold_state == HS_FAULT) begin
                            pend_next.status = ST_BADSTATE;
                        end else begin
                            ram_we = 1'b1;
                            ram_wdata.cmd_time = item_reg.now_us;
                            ram_wdata.hold_state = HS_CMD;
                            pend_next.applied_bits = item_reg.level_bits;
                            pend_next.drive_valid = 1'b1;
                            pend_next.hold_state = HS_CMD;
                        end
                    end
                    MODE_RENEW: begin
                        if (latch_reg) begin
                            pend_next.status = ST_INTERLOCK;
                        end else if (!found_reg) begin
                            pend_next.status = ST_NOTFOUND;
                        end else if (ent_reg.hold_state != HS_CMD) begin
                            pend_next.status = ST_BADSTATE;
                        end else begin
                            ram_we = 1'b1;
                            ram_wdata.cmd_time = item_reg.now_us;
                            pend_next.hold_state = HS_CMD;
                        end
                    end
                    MODE_RELEASE: begin
                        if (item_reg.release_state > HS_TRIPPED) begin
                            pend_next.status = ST_BADARG;
                        end else if (!found_reg) begin
                            pend_next.status = ST_NOTFOUND;
                        end else begin
                            ram_we = 1'b1;
                            ram_wdata.hold_state = item_reg.release_state;
                            pend_next.applied_bits = ent_reg.safe_bits;
                            pend_next.drive_valid = 1'b1;
                            pend_next.hold_state = item_reg.release_state;
                        end
                    end
                    default: begin
                        pend_valid_next = 1'b1;
                    end
                endcase
            end
            S_WALK_RD: begin
                if (idx_reg == cnt_reg && item_reg.mode == MODE_TICK && !pass_reg) begin
                    pass_next = 1'b1;
                    idx_next = '0;
                end
            end
            S_WALK_CHK: begin
                if (can_go) begin
                    ram_we = ev.wr;
                    ram_waddr = idx_reg[AW-1:0];
                    ram_wdata = ev.wdata;
                    if (ev.cand) begin
                        pend_next = ev.res;
                        pend_valid_next = 1'b1;
                        load = pend_valid_reg;
                    end
                    if (item_reg.mode == MODE_TICK && !pass_reg && ev.expire
                        && exp_reg != 16'hFFFF) begin
                        exp_next = exp_reg + 16'd1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DROP_RD: ram_raddr = idx_m1[AW-1:0];
            S_DROP_CHK: begin
                ram_raddr = idx_m1[AW-1:0];
                if (ev.dev_match) begin
                    dst_next = idx_m1[AW-1:0];
                end else begin
                    idx_next = idx_m1;
                end
            end
            S_COPY_RD: ram_raddr = cnt_m1[AW-1:0];
            S_COPY_WR: begin
                ram_raddr = cnt_m1[AW-1:0];
                ram_we = 1'b1;
                ram_wdata = ram_rdata;
                cnt_next = cnt_m1;
                if (item_reg.mode == MODE_FORGET_DEV) begin
                    idx_next = idx_m1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    load = 1'b1;
                    load_last = 1'b1;
                    load_res = pend_valid_reg ? pend_reg
                                              : plain_res(ST_OK, item_reg.channel_id);
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        if (load) begin
            m_valid_next = 1'b1;
            m_data_next.status = load_res.status;
            m_data_next.out_channel = load_res.out_channel;
            m_data_next.applied_bits = load_res.applied_bits;
            m_data_next.drive_valid = load_res.drive_valid;
            m_data_next.hold_state = load_res.hold_state;
            m_data_next.event_valid = load_res.event_valid;
            m_data_next.event_cause = load_res.event_cause;
            m_data_next.severity = load_res.severity;
            m_data_next.tripped = latch_reg;
            m_data_next.trip_count = trips_reg;
            m_data_next.expiry_count = exp_reg;
            m_data_next.last = load_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            pend_valid_reg <= 1'b0;
            latch_reg <= 1'b0;
            trips_reg <= '0;
            exp_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            latch_reg <= latch_next;
            trips_reg <= trips_next;
            exp_reg <= exp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        idx_reg <= idx_next;
        dst_reg <= dst_next;
        found_reg <= found_next;
        ent_reg <= ent_next;
        pend_reg <= pend_next;
        pass_reg <= pass_next;
        m_data_reg <= m_data_next;
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_OUTPUTS))
        else $error("table count above capacity");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> out_free)
        else $error("result beat overwritten while stalled");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_valid_reg)
        else $error("pending result left over at idle");

    a_trip_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.mode == MODE_TRIP) |=> latch_reg)
        else $error("trip did not latch");
endmodule
